@@ rtl/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sha256 package
// shared types, constants and round functions for the sha-256 hasher
// ------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned ByteTotalWidth = 61;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic store_byte;
        logic load_vars;
        logic do_round;
        logic add_hash;
        logic pad_start;
        logic pad_second;
        logic emit_shift;
        logic reset_hash;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic block_full;
        logic total_sat;
        logic pad_two;
        logic round_last;
    } t_stat;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/sha256_ctrl.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sha256 controller
// sequences byte intake, compression rounds, padding and digest output
// ------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_byte_valid,
    input  logic                i_last,
    input  logic                i_out_ready,
    input  sha256_pkg::t_stat   i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic                o_out_final,
    output sha256_pkg::t_cmd    o_cmd
);
    import sha256_pkg::*;

    t_state     r_state, n_state;
    logic       r_fin, n_fin;     // finalize pending after current block
    logic       r_pad2, n_pad2;   // second padding block pending
    logic       r_done, n_done;   // padding already happened for this message
    logic [2:0] r_cnt, n_cnt;
    logic       w_take, w_store;

    assign w_take  = i_in_valid && (r_state == ST_IDLE);
    assign w_store = w_take && i_byte_valid && !i_stat.total_sat;

    // next state
    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_pad2  = r_pad2;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (w_store && i_stat.block_full) begin
                        n_fin   = i_last;
                        n_state = ST_LOAD;
                    end else if (i_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_pad2  = i_stat.pad_two;
                n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_ROUND;
            ST_ROUND: if (i_stat.round_last) n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (r_pad2) begin
                    n_pad2  = 1'b0;
                    n_state = ST_LOAD;
                end else if (r_fin) begin
                    n_fin   = 1'b0;
                    n_state = ST_PAD;
                end else if (r_done) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // padding done flag, cleared after the last digest word
    always_comb begin
        n_done = r_done;
        if (r_state == ST_PAD) n_done = 1'b1;
        if (r_state == ST_EMIT && i_out_ready && r_cnt == 3'd7) n_done = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 1'b0;
            r_pad2  <= 1'b0;
            r_cnt   <= 3'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_pad2  <= n_pad2;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_in_ready       = (r_state == ST_IDLE);
        o_out_valid      = (r_state == ST_EMIT);
        o_out_final      = (r_state == ST_EMIT) && (r_cnt == 3'd7);
        o_cmd.store_byte = w_store;
        o_cmd.load_vars  = (r_state == ST_LOAD);
        o_cmd.do_round   = (r_state == ST_ROUND);
        o_cmd.add_hash   = (r_state == ST_UPDATE);
        o_cmd.pad_start  = (r_state == ST_PAD);
        o_cmd.pad_second = (r_state == ST_UPDATE) && r_pad2;
        o_cmd.emit_shift = (r_state == ST_EMIT) && i_out_ready;
        o_cmd.reset_hash = (r_state == ST_EMIT) && i_out_ready && (r_cnt == 3'd7);
    end

endmodule

@@ rtl/sha256_dp.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sha256 datapath
// schedule window that also collects the block, round unit and hash state
// ------------------------------------------------------------------------
module sha256_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data_byte,
    input  sha256_pkg::t_cmd    i_cmd,
    output sha256_pkg::t_stat   o_stat,
    output logic [31:0]         o_digest_word
);
    import sha256_pkg::*;

    logic [ByteTotalWidth-1:0] r_total;
    logic [31:0]               r_h [8];
    logic [31:0]               r_v [8];
    logic [31:0]               r_w [16];
    logic [31:0]               w_pad [16];
    logic [31:0]               w_ins;
    logic [5:0]                r_t;
    logic [5:0]                w_idx;
    logic [63:0]               w_bits;
    logic [31:0]               w_wt, w_wn, w_s0, w_s1, w_t1, w_t2, w_e, w_a;

    assign w_idx  = r_total[5:0];
    assign w_bits = {r_total, 3'b000};

    assign o_stat.block_full = (w_idx == 6'd63);
    assign o_stat.total_sat  = (r_total == {ByteTotalWidth{1'b1}});
    assign o_stat.pad_two    = (w_idx >= 6'd56);
    assign o_stat.round_last = (r_t == 6'd63);
    assign o_digest_word     = r_h[0];

    // schedule word for this round
    assign w_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wn = r_w[0] + w_s0 + r_w[9] + w_s1;
    assign w_wt = r_w[0];

    // round function
    assign w_a  = r_v[0];
    assign w_e  = r_v[4];
    assign w_t1 = r_v[7] + (rotr(w_e, 6) ^ rotr(w_e, 11) ^ rotr(w_e, 25))
                + ((w_e & r_v[5]) ^ (~w_e & r_v[6])) + round_k(r_t) + w_wt;
    assign w_t2 = (rotr(w_a, 2) ^ rotr(w_a, 13) ^ rotr(w_a, 22))
                + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));

    // big-endian byte insert into the current block word
    always_comb begin
        w_ins = r_w[w_idx[5:2]];
        case (w_idx[1:0])
            2'd0: w_ins[31:24] = i_data_byte;
            2'd1: w_ins[23:16] = i_data_byte;
            2'd2: w_ins[15:8]  = i_data_byte;
            2'd3: w_ins[7:0]   = i_data_byte;
            default: w_ins = r_w[w_idx[5:2]];
        endcase
    end

    // padded block image: 0x80 marker, zero fill, bit length
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            w_pad[j] = r_w[j];
            if (i_cmd.pad_second) begin
                w_pad[j] = 32'h0;
            end else begin
                for (int b = 0; b < 4; b++) begin
                    if (6'(4*j+b) == w_idx) w_pad[j][31-8*b -: 8] = 8'h80;
                    else if (6'(4*j+b) > w_idx) w_pad[j][31-8*b -: 8] = 8'h00;
                end
            end
        end
        if (i_cmd.pad_second || (w_idx < 6'd56)) begin
            w_pad[14] = w_bits[63:32];
            w_pad[15] = w_bits[31:0];
        end
    end

    // byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_hash) r_total <= '0;
        else if (i_cmd.store_byte) r_total <= r_total + 1'b1;
    end

    // block collection, padding and schedule window
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) begin
            r_w[w_idx[5:2]] <= w_ins;
        end else if (i_cmd.pad_start || i_cmd.pad_second) begin
            for (int j = 0; j < 16; j++) r_w[j] <= w_pad[j];
        end else if (i_cmd.do_round) begin
            for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
            r_w[15] <= w_wn;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
        end else if (i_cmd.do_round) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= w_e;
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= w_a;
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // round counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_vars) r_t <= '0;
        else if (i_cmd.do_round) r_t <= r_t + 6'd1;
    end

    // hash state, rotated out during emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_hash) begin
            for (int j = 0; j < 8; j++) r_h[j] <= init_hash(3'(j));
        end else if (i_cmd.add_hash) begin
            for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
        end else if (i_cmd.emit_shift) begin
            for (int j = 0; j < 7; j++) r_h[j] <= r_h[j+1];
            r_h[7] <= r_h[0];
        end
    end

endmodule

@@ rtl/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sha256 stream hasher
// byte-stream sha-256 with padding and digest output
// ------------------------------------------------------------------------
// input: one byte per transaction; tdata[7:0] is the byte, tuser marks it
// valid, tlast ends the message. output: eight 32-bit digest words, word 0
// first, tlast on the eighth.
// a byte that does not fill a block is stored without holding intake. the
// 64th byte of a block holds intake for a load of the working variables,
// 64 rounds on the single shared round unit and a hash update. on tlast,
// padding and one or two compressions run; the digest is then shown one word
// per cycle while the receiver takes it; a stalled receiver holds the word.
// input is not taken during compression, padding or digest output.
// after the digest the hash state returns to the initial values by itself.
// reset: synchronous, active low; clears the byte count and hash state.
// ------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast    // final_word
);
    import sha256_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_byte_valid (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .i_stat       (w_stat),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_final  (m_axis_tlast),
        .o_cmd        (w_cmd)
    );

    sha256_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (s_axis_tdata),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_digest_word (m_axis_tdata)
    );

`ifndef SYNTH
    // no input taken while digest words are shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("in and out overlap");
    // final word handshake ends output
    a_end_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("output continues after final word");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sha256 stream hasher testbench
// drives byte transactions into the hasher, predicts each digest with a
// behavioral sha-256 and checks every digest word and its final flag
// ------------------------------------------------------------------------
module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // byte_valid
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic        m_axis_tlast;   // final_word

    typedef struct packed {
        logic [31:0] word;
        logic        fin;
    } t_digest_word;

    localparam logic [60:0] TotalMax = {61{1'b1}};

    // hash model state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_bytes;
    t_digest_word digest_queue [$];

    int errors;
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;

    sha256_stream_hasher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of msg_block into hash_state
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(t[5:0]) + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] += v[j];
    endtask

    task automatic restart_hash();
        for (int j = 0; j < 8; j++) hash_state[j] = sha256_pkg::init_hash(j[2:0]);
        msg_bytes = '0;
    endtask

    // predict the digest words caused by one accepted transaction
    task automatic predict_digest(input logic [7:0] b, input logic bv, input logic lst);
        int idx;
        logic [63:0] bits;
        t_digest_word dw;
        if (bv && msg_bytes != TotalMax) begin
            idx = int'(msg_bytes[5:0]);
            msg_block[idx] = b;
            msg_bytes++;
            if (idx == 63) compress_block();
        end
        if (!lst) return;
        idx = int'(msg_bytes[5:0]);
        bits = {msg_bytes, 3'b000};
        msg_block[idx] = 8'h80;
        for (int i = idx + 1; i < 64; i++) msg_block[i] = 8'h00;
        if (idx >= 56) begin
            compress_block();
            for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            dw.word = hash_state[i];
            dw.fin  = (i == 7);
            digest_queue.push_back(dw);
        end
        restart_hash();
    endtask

    // send one transaction, with random idle cycles before it
    task automatic send_byte(input logic [7:0] b, input logic bv, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= bv;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_digest(b, bv, lst);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), 1'b1, (i == len - 1));
        if (len == 0) send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // receiver ready
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // check each digest word
    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_queue.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest word %h", m_axis_tdata);
            end else begin
                exp_w = digest_queue.pop_front();
                if (exp_w.word !== m_axis_tdata || exp_w.fin !== m_axis_tlast) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: expected %h/%b got %h/%b",
                                 exp_w.word, exp_w.fin, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // extremes, empty message, no-byte items
    task automatic test_directed();
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h5a, 1'b0, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h62, 1'b1, 1'b0);
        send_byte(8'h63, 1'b1, 1'b1);
    endtask

    // lengths around the one- and two-block padding split
    task automatic test_pad_bounds();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
    endtask

    // random messages, mostly short, with idle items mixed in
    task automatic test_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
                sent++;
            end else begin
                len = ($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(20);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(255)), ($urandom_range(15) != 0), 1'b0);
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                sent += len + 1;
            end
        end
    endtask

    task automatic drain_digests();
        s_axis_tvalid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        errors        = 0;
        mismatches    = 0;
        send_idle_pct = 36;
        recv_idle_pct = 74;
        restart_hash();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_pad_bounds();
        test_random(55);
        drain_digests();
        send_idle_pct = 74;
        recv_idle_pct = 36;
        test_random(55);
        drain_digests();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(55);
        drain_digests();

        if (errors == 0) begin
            $display("[sha256_stream_hasher] OK");
        end else begin
            $display("[sha256_stream_hasher] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #30ms;
        $display("[sha256_stream_hasher] ERROR");
        $finish;
    end

endmodule
